>>> hw/rtl/fbpa_pkg.sv
// fbpa_pkg: types, codes and reset values shared by the block pool allocator.
// Depends on nothing; imported by the controller, the datapath and the top level.
package fbpa_pkg;

   // Operation codes of a request
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_POOL_BASE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_SHIFT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_COUNT = 2'd2;

   // Configuration reset values
   localparam logic [31:0] POOL_BASE_RST   = 32'd0;
   localparam logic [4:0]  BLOCK_SHIFT_RST = 5'd6;
   localparam logic [8:0]  BLOCK_COUNT_RST = 9'd256;

   // Largest in-use value the response can carry
   localparam logic [8:0] IN_USE_MAX = 9'd511;

   typedef enum logic [2:0] {
      ST_GRANT    = 3'd0,
      ST_FALLBACK = 3'd1,
      ST_ZERO     = 3'd2,
      ST_RETURNED = 3'd3,
      ST_NULL     = 3'd4,
      ST_OUTSIDE  = 3'd5
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } ctrl_state_type;

   typedef struct packed {
      logic        operation;
      logic [31:0] request_size;
      logic [31:0] address_in;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] address_out;
      logic [8:0]  in_use;
      logic [8:0]  peak_in_use;
      logic [31:0] alloc_total;
      logic [31:0] free_total;
   } rsp_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // latch the accepted request and its precomputed flags
      logic commit;    // execute the latched request, load the response register
      logic csr_write; // configuration write handshake completes
   } cmd_type;

endpackage

>>> hw/rtl/fbpa_ctrl.sv
// fbpa_ctrl: request sequencing state machine and response valid flag.
// Depends on fbpa_pkg; drives the command struct of fbpa_dp.
module fbpa_ctrl
   import fbpa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  logic    csr_valid,
   output logic    csr_ready,
   output cmd_type cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // State register and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands; a pending register write goes ahead of a request
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = !csr_valid;
            if (req_valid && !csr_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            // execute once the response slot is free or being emptied
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      cmd.csr_write = csr_valid && csr_ready;
   end

   // Response slot occupancy
   always_comb begin
      priority if (cmd.commit) rsp_valid_in = 1'b1;
      else if (rsp_ready)      rsp_valid_in = 1'b0;
      else                     rsp_valid_in = rsp_valid_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   // register writes only between requests, never with one in execute
   assign csr_ready = (state_ff == S_IDLE);

   // A captured request is executed in the cycle after capture or later
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_EXEC))
      else $error("accepted request did not enter execute");

   // Never overwrite a response that has not been taken
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten before being taken");

   // Every commit presents a response in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("commit without response");

   // Capture and commit never coincide
   assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> !cmd.commit)
      else $error("capture and commit in the same cycle");

endmodule

>>> hw/rtl/fbpa_dp.sv
// fbpa_dp: configuration registers, free-list head, link memory, counters and
// response register. Depends on fbpa_pkg; commanded by fbpa_ctrl.
module fbpa_dp
   import fbpa_pkg::*;
#(
   parameter int MAX_BLOCKS = 256
)(
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   input  req_type                req_data,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_wdata,
   output rsp_type                rsp_data
);

   localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNT_W = IDX_W + 1;
   localparam logic [31:0] MAX_LIMIT = 32'(MAX_BLOCKS);

   // Saturated view of the grant/return difference
   function automatic logic [8:0] sat_in_use(input logic [31:0] d);
      logic [8:0] r;
      if (d[31])         r = 9'd0;
      else if (|d[30:9]) r = IN_USE_MAX;
      else               r = d[8:0];
      return r;
   endfunction

   // Configuration
   logic [31:0] pool_base_ff;
   logic [4:0]  block_shift_ff;
   logic [8:0]  block_count_ff;
   logic        reinit;

   // Latched request with flags computed at capture
   logic        op_ff;
   logic        size_zero_ff;
   logic        oversize_ff;
   logic        addr_null_ff;
   logic        below_base_ff;
   logic [31:0] offset_ff;

   // Free list and counters
   logic [IDX_W-1:0] head_ff, head_in;
   logic             head_valid_ff, head_valid_in;
   logic [CNT_W-1:0] fresh_ff, fresh_in;
   logic [31:0]      grant_ff, grant_in;
   logic [31:0]      ret_ff, ret_in;
   logic [31:0]      diff_ff, diff_in;
   logic [8:0]       peak_ff, peak_in;

   // Link memory: {valid, next index}; link_ff holds the entry at the current head
   logic [IDX_W:0]   link_mem [MAX_BLOCKS];
   logic [IDX_W:0]   link_ff;
   logic [IDX_W:0]   link_wdata;
   logic             link_we;

   rsp_type          rsp_ff, rsp_in;

   // Execute-cycle decode
   logic [31:0]      active_n;
   logic             exhausted;
   logic             grant_ok;
   logic             free_ok;
   logic [IDX_W-1:0] pop_idx;
   logic [IDX_W-1:0] free_idx;
   logic [31:0]      block_q;
   logic             in_pool;
   logic [8:0]       use_after;
   status_type       status;

   assign reinit = cmd.csr_write &&
                   (csr_index == CSR_POOL_BASE || csr_index == CSR_BLOCK_SHIFT ||
                    csr_index == CSR_BLOCK_COUNT);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff   <= POOL_BASE_RST;
         block_shift_ff <= BLOCK_SHIFT_RST;
         block_count_ff <= BLOCK_COUNT_RST;
      end else if (cmd.csr_write) begin
         unique case (csr_index)
            CSR_POOL_BASE:   pool_base_ff   <= csr_wdata;
            CSR_BLOCK_SHIFT: block_shift_ff <= csr_wdata[4:0];
            CSR_BLOCK_COUNT: block_count_ff <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   // Request capture: size and address checks that need no pool state
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff         <= req_data.operation;
         size_zero_ff  <= (req_data.request_size == 32'd0);
         oversize_ff   <= ({1'b0, req_data.request_size} > (33'd1 << block_shift_ff));
         addr_null_ff  <= (req_data.address_in == 32'd0);
         below_base_ff <= (req_data.address_in < pool_base_ff);
         offset_ff     <= req_data.address_in - pool_base_ff;
      end
   end

   // Decode of the latched request
   always_comb begin
      active_n  = ({23'd0, block_count_ff} > MAX_LIMIT) ? MAX_LIMIT
                                                        : {23'd0, block_count_ff};
      exhausted = !head_valid_ff && ({{(32-CNT_W){1'b0}}, fresh_ff} >= active_n);
      block_q   = offset_ff >> block_shift_ff;
      in_pool   = (block_q < active_n);
      free_idx  = block_q[IDX_W-1:0];
      pop_idx   = head_valid_ff ? head_ff : fresh_ff[IDX_W-1:0];

      if (op_ff == OP_ALLOC) begin
         if (size_zero_ff)                  status = ST_ZERO;
         else if (oversize_ff || exhausted) status = ST_FALLBACK;
         else                               status = ST_GRANT;
      end else begin
         if (addr_null_ff)                   status = ST_NULL;
         else if (below_base_ff || !in_pool) status = ST_OUTSIDE;
         else                                status = ST_RETURNED;
      end

      grant_ok = cmd.commit && (status == ST_GRANT);
      free_ok  = cmd.commit && (status == ST_RETURNED);
   end

   // Next state of the free list and counters
   always_comb begin
      head_in       = head_ff;
      head_valid_in = head_valid_ff;
      fresh_in      = fresh_ff;
      grant_in      = grant_ff;
      ret_in        = ret_ff;
      diff_in       = diff_ff;
      peak_in       = peak_ff;
      link_we       = 1'b0;
      link_wdata    = {head_valid_ff, head_ff};
      use_after     = sat_in_use(diff_ff + 32'd1);

      priority if (reinit) begin
         head_in       = '0;
         head_valid_in = 1'b0;
         fresh_in      = '0;
         grant_in      = 32'd0;
         ret_in        = 32'd0;
         diff_in       = 32'd0;
         peak_in       = 9'd0;
      end else if (grant_ok) begin
         // pop: prefetched link of the head, or next fresh block
         if (head_valid_ff) begin
            head_in       = link_ff[IDX_W-1:0];
            head_valid_in = link_ff[IDX_W];
         end else begin
            fresh_in = fresh_ff + CNT_W'(1);
         end
         grant_in = grant_ff + 32'd1;
         diff_in  = diff_ff + 32'd1;
         if (use_after > peak_ff) peak_in = use_after;
      end else if (free_ok) begin
         // push: old head becomes the link of the returned block
         link_we       = 1'b1;
         head_in       = free_idx;
         head_valid_in = 1'b1;
         ret_in        = ret_ff + 32'd1;
         diff_in       = diff_ff - 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         head_valid_ff <= 1'b0;
         fresh_ff      <= '0;
         grant_ff      <= 32'd0;
         ret_ff        <= 32'd0;
         diff_ff       <= 32'd0;
         peak_ff       <= 9'd0;
      end else begin
         head_ff       <= head_in;
         head_valid_ff <= head_valid_in;
         fresh_ff      <= fresh_in;
         grant_ff      <= grant_in;
         ret_ff        <= ret_in;
         diff_ff       <= diff_in;
         peak_ff       <= peak_in;
      end
   end

   // Link memory; read port follows the next head, write data forwarded on a hit
   always_ff @(posedge clock) begin
      if (link_we) link_mem[free_idx] <= link_wdata;
      if (link_we && (free_idx == head_in)) link_ff <= link_wdata;
      else                                  link_ff <= link_mem[head_in];
   end

   // Response register
   always_comb begin
      rsp_in.status      = status;
      rsp_in.address_out = (status == ST_GRANT)
                           ? pool_base_ff + (32'(pop_idx) << block_shift_ff) : 32'd0;
      rsp_in.in_use      = sat_in_use(diff_in);
      rsp_in.peak_in_use = peak_in;
      rsp_in.alloc_total = grant_in;
      rsp_in.free_total  = ret_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

>>> hw/rtl/fixed_block_pool_allocator_top.sv
// Fixed-size block pool allocator, LIFO free list of MAX_BLOCKS blocks.
// Each request is handled in two steps: capture, which runs the size and
// address checks, and execute, which updates the free list and loads the
// response register; a request is taken only after the previous one has
// executed. The link of the current head block is held prefetched from
// the link memory, which lets a pop finish in the execute cycle. A request
// is accepted while the previous response still waits; the execute cycle
// waits until that response is taken. The link memory is not cleared after
// reset or a configuration write; never-used blocks come from a fresh
// counter, so no clearing pass is needed. A write to any listed register
// reinitializes the pool. Depends on fbpa_pkg, fbpa_ctrl and fbpa_dp.
module fixed_block_pool_allocator_top
   import fbpa_pkg::*;
#(
   parameter int MAX_BLOCKS = 256
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_wdata
);

   cmd_type cmd;

   // Sequencing
   fbpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .cmd       (cmd)
   );

   // Pool state and response
   fbpa_dp #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

endmodule
